// ===== sv/apcl_pkg.sv =====
// Package for the pointer click-layer controller: mode codes, register
// indexes, reset values and the configuration bundle. No dependencies.
`timescale 1ns / 1ps

package apcl_pkg;

  // Operating modes of the click layer.
  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_WAITING   = 2'd1,
    MODE_CLICKABLE = 2'd2,
    MODE_CLICKING  = 2'd3
  } mode_e;

  // Item kinds on the input channel.
  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_KEY    = 1'b1;

  // Key kind code for a key that is not a click button.
  localparam logic [1:0] KIND_OTHER = 2'd0;

  // Configuration register indexes.
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_HOLD_TIME = 2'd1;
  localparam logic [1:0] REG_WAIT_TIME = 2'd2;

  // Register reset values.
  localparam logic [14:0] THRESHOLD_RST = 15'd0;
  localparam logic [15:0] HOLD_TIME_RST = 16'd800;
  localparam logic [15:0] WAIT_TIME_RST = 16'd50;

  // Ceiling of the motion accumulator.
  localparam logic [14:0] SUM_MAX = 15'h7FFF;

  // Default number of click buttons.
  localparam int NUM_BUTTONS_DEF = 3;

  // Configuration as seen by the update logic.
  typedef struct packed {
    logic [14:0] threshold;
    logic [15:0] hold_time;
    logic [15:0] wait_time;
  } apcl_cfg_t;

endpackage

// ===== sv/apcl_core.sv =====
// State and update logic of the click-layer controller: holds the mode,
// time mark, motion sum, layer flag and button mask. Depends on apcl_pkg.
`timescale 1ns / 1ps

module apcl_core #(
  parameter int NumButtons = apcl_pkg::NUM_BUTTONS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  apcl_pkg::apcl_cfg_t   cfg_i,
  input  logic                  fire_i,
  input  logic                  cmd_i,
  input  logic [15:0]           now_ms_i,
  input  logic signed [7:0]     dx_i,
  input  logic signed [7:0]     dy_i,
  input  logic [1:0]            key_kind_i,
  input  logic                  pressed_i,
  output logic                  layer_active_o,
  output logic [1:0]            mode_o,
  output logic [NumButtons-1:0] buttons_o,
  output logic                  send_report_o,
  output logic                  key_passes_o,
  output logic signed [7:0]     out_dx_o,
  output logic signed [7:0]     out_dy_o
);

  import apcl_pkg::*;

  mode_e                 mode_q, mode_d;
  logic [15:0]           mark_q, mark_d;
  logic [14:0]           sum_q, sum_d;
  logic                  layer_q, layer_d;
  logic [NumButtons-1:0] mask_q, mask_d;

  logic [7:0]            mag_x, mag_y;
  logic [15:0]           sum_raw;
  logic [14:0]           sum_sat;
  logic [15:0]           elapsed;
  logic                  moving;
  logic                  is_button;
  logic [NumButtons-1:0] button_bit;

  // Magnitudes of the motion; full negative counts as 128.
  assign mag_x = dx_i[7] ? (~dx_i + 8'd1) : dx_i;
  assign mag_y = dy_i[7] ? (~dy_i + 8'd1) : dy_i;
  assign moving = (mag_x != 8'd0) || (mag_y != 8'd0);

  // Saturating motion accumulation.
  assign sum_raw = {1'b0, sum_q} + {8'd0, mag_x} + {8'd0, mag_y};
  assign sum_sat = sum_raw[15] ? SUM_MAX : sum_raw[14:0];

  // Time since the mark, wrapping at 16 bits.
  assign elapsed = now_ms_i - mark_q;

  // Click button decode; buttons beyond the configured count act as other keys.
  assign is_button  = (key_kind_i != KIND_OTHER) && (int'(key_kind_i) <= NumButtons);
  assign button_bit = NumButtons'(1) << (key_kind_i - 2'd1);

  // Next state and result fields for the item in the input register.
  always_comb begin
    mode_d         = mode_q;
    mark_d         = mark_q;
    sum_d          = sum_q;
    layer_d        = layer_q;
    mask_d         = mask_q;
    send_report_o  = 1'b0;
    key_passes_o   = 1'b0;
    out_dx_o       = '0;
    out_dy_o       = '0;

    if (cmd_i == CMD_KEY) begin
      if (is_button) begin
        if (pressed_i) begin
          mask_d = mask_q | button_bit;
          mode_d = MODE_CLICKING;
        end else begin
          mask_d  = mask_q & ~button_bit;
          layer_d = 1'b1;
          mark_d  = now_ms_i;
          mode_d  = MODE_CLICKABLE;
        end
        send_report_o = 1'b1;
      end else begin
        if (pressed_i) begin
          mode_d  = MODE_IDLE;
          layer_d = 1'b0;
        end
        key_passes_o = 1'b1;
      end
    end else begin
      out_dx_o = dx_i;
      out_dy_o = dy_i;
      if (moving) begin
        case (mode_q)
          MODE_CLICKABLE: begin
            mark_d = now_ms_i;
          end
          MODE_WAITING: begin
            if (sum_sat >= cfg_i.threshold) begin
              sum_d   = '0;
              layer_d = 1'b1;
              mark_d  = now_ms_i;
              mode_d  = MODE_CLICKABLE;
            end else begin
              sum_d = sum_sat;
            end
          end
          MODE_IDLE: begin
            mark_d = now_ms_i;
            mode_d = MODE_WAITING;
            sum_d  = '0;
          end
          default: begin
          end
        endcase
      end else begin
        case (mode_q)
          MODE_CLICKABLE: begin
            if (elapsed > cfg_i.hold_time) begin
              mode_d  = MODE_IDLE;
              layer_d = 1'b0;
            end
          end
          MODE_WAITING: begin
            if (elapsed > cfg_i.wait_time) begin
              sum_d  = '0;
              mode_d = MODE_IDLE;
            end
          end
          MODE_IDLE: begin
            sum_d = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The result shows the state after the item.
  assign layer_active_o = layer_d;
  assign mode_o         = mode_d;
  assign buttons_o      = mask_d;

  // State registers, updated once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      mark_q  <= '0;
      sum_q   <= '0;
      layer_q <= 1'b0;
      mask_q  <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      mark_q  <= mark_d;
      sum_q   <= sum_d;
      layer_q <= layer_d;
      mask_q  <= mask_d;
    end
  end

endmodule

// ===== sv/auto_pointer_click_layer_fsm.sv =====
// Top level of the pointer click-layer controller: input register, result
// register, configuration registers and the apcl_core update logic.
// Depends on apcl_pkg and apcl_core.
//
//   Channel  Direction  Handshake                  Payload
//   cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o    cmd, now_ms, dx, dy, key_kind, pressed
//   out      out        out_valid_o / out_stall_i  layer_active, mode, buttons, ...
//
// A beat is registered in the input register on entry and its result in the
// result register; one beat can enter every cycle while the output does not stall.
// The combinational state update between the two registers sets the rate.
// Reset is asynchronous and active low; it clears the mode, mark, motion sum,
// layer flag, button mask and valid flags and loads the config reset values.
// A stall on the output holds the result; the input register then fills
// and the input stalls in turn. Register writes are always ready.
`timescale 1ns / 1ps

module auto_pointer_click_layer_fsm #(
  parameter int NumButtons = apcl_pkg::NUM_BUTTONS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [15:0]           now_ms_i,
  input  logic signed [7:0]     dx_i,
  input  logic signed [7:0]     dy_i,
  input  logic [1:0]            key_kind_i,
  input  logic                  pressed_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  layer_active_o,
  output logic [1:0]            mode_o,
  output logic [NumButtons-1:0] buttons_o,
  output logic                  send_report_o,
  output logic                  key_passes_o,
  output logic signed [7:0]     out_dx_o,
  output logic signed [7:0]     out_dy_o
);

  import apcl_pkg::*;

  apcl_cfg_t             cfg_q;

  logic                  s1_valid_q;
  logic                  s1_cmd_q;
  logic [15:0]           s1_now_q;
  logic signed [7:0]     s1_dx_q, s1_dy_q;
  logic [1:0]            s1_kind_q;
  logic                  s1_pressed_q;

  logic                  out_valid_q;
  logic                  out_layer_q;
  logic [1:0]            out_mode_q;
  logic [NumButtons-1:0] out_buttons_q;
  logic                  out_send_q;
  logic                  out_passes_q;
  logic signed [7:0]     out_dx_q, out_dy_q;

  logic                  in_take;
  logic                  s1_fire;
  logic                  out_take;

  logic                  res_layer;
  logic [1:0]            res_mode;
  logic [NumButtons-1:0] res_buttons;
  logic                  res_send;
  logic                  res_passes;
  logic signed [7:0]     res_dx, res_dy;

  // Handshake control.
  assign out_take    = out_valid_q && !out_stall_i;
  assign s1_fire     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !s1_fire;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESHOLD_RST;
      cfg_q.hold_time <= HOLD_TIME_RST;
      cfg_q.wait_time <= WAIT_TIME_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_THRESHOLD: cfg_q.threshold <= cfg_data_i[14:0];
        REG_HOLD_TIME: cfg_q.hold_time <= cfg_data_i;
        REG_WAIT_TIME: cfg_q.wait_time <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q     <= cmd_i;
      s1_now_q     <= now_ms_i;
      s1_dx_q      <= dx_i;
      s1_dy_q      <= dy_i;
      s1_kind_q    <= key_kind_i;
      s1_pressed_q <= pressed_i;
    end
  end

  apcl_core #(
    .NumButtons(NumButtons)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .fire_i        (s1_fire),
    .cmd_i         (s1_cmd_q),
    .now_ms_i      (s1_now_q),
    .dx_i          (s1_dx_q),
    .dy_i          (s1_dy_q),
    .key_kind_i    (s1_kind_q),
    .pressed_i     (s1_pressed_q),
    .layer_active_o(res_layer),
    .mode_o        (res_mode),
    .buttons_o     (res_buttons),
    .send_report_o (res_send),
    .key_passes_o  (res_passes),
    .out_dx_o      (res_dx),
    .out_dy_o      (res_dy)
  );

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_layer_q   <= res_layer;
      out_mode_q    <= res_mode;
      out_buttons_q <= res_buttons;
      out_send_q    <= res_send;
      out_passes_q  <= res_passes;
      out_dx_q      <= res_dx;
      out_dy_q      <= res_dy;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign layer_active_o = out_layer_q;
  assign mode_o         = out_mode_q;
  assign buttons_o      = out_buttons_q;
  assign send_report_o  = out_send_q;
  assign key_passes_o   = out_passes_q;
  assign out_dx_o       = out_dx_q;
  assign out_dy_o       = out_dy_q;

endmodule
